### hdl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// implication or plain property checked on every clock outside reset
`define RGM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rgm assertion failed");
// condition that must never be seen outside reset
`define RGM_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("rgm forbidden condition");
`else
`define RGM_ASSERT(lbl, prop)
`define RGM_NEVER(lbl, cond)
`endif

`endif

### hdl/rgm_pkg.sv
package rgm_pkg;

	localparam int DEF_CHANNELS   = 4;
	localparam int DEF_FRAC_BITS  = 20;

	localparam int SAMPLE_W      = 24;
	localparam int SAMPLE_INPUTS = 4;
	localparam int BLOCKS_W      = 16;
	localparam int POS_W         = 10;
	localparam int LOG2_W        = 4;
	localparam int GAIN_W        = 42;
	localparam int LO_W          = 21;
	localparam int HI_W          = GAIN_W - LO_W;
	localparam int PROD_W        = 46;
	localparam int ACC_W         = 64;
	localparam int QUEUE_DEPTH   = 4;

	localparam logic [LOG2_W-1:0] LOG2_RESET = 4'd6;
	localparam logic [LOG2_W-1:0] MAX_LOG2   = 4'd10;

	localparam logic signed [ACC_W-1:0] OUT_MAX = 64'sd8388607;
	localparam logic signed [ACC_W-1:0] OUT_MIN = -64'sd8388608;

	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_RAMP  = 1'b1;

	typedef struct packed {
		logic                                      is_ramp;
		logic [1:0]                                channel;
		logic [SAMPLE_W-1:0]                       target;
		logic [BLOCKS_W-1:0]                       blocks;
		logic [SAMPLE_INPUTS-1:0][SAMPLE_W-1:0]    samples;
		logic [SAMPLE_INPUTS-1:0]                  present;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CH,
		ST_DIV,
		ST_BLK,
		ST_MLO,
		ST_MHI,
		ST_ACC,
		ST_FIN
	} back_state_t;

endpackage

### hdl/rgm_front.sv
`include "assert_macros.svh"

module rgm_front #(
	parameter int CHANNELS = rgm_pkg::DEF_CHANNELS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  rgm_pkg::item_t in_item,
	output logic          q_valid,
	output rgm_pkg::item_t q_item,
	input  logic          q_pop
);

	localparam int PTR_W = $clog2(rgm_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(rgm_pkg::QUEUE_DEPTH + 1);

	rgm_pkg::item_t      mem_q [rgm_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                keep;
	logic                push;
	logic                pop;

	// set-ramp items for missing channels are dropped here
	assign keep     = (in_item.is_ramp == rgm_pkg::OP_FRAME) ||
		(32'(in_item.channel) < CHANNELS);
	assign in_stall = (count_q == CNT_W'(rgm_pkg::QUEUE_DEPTH));
	assign push     = in_valid && !in_stall && keep;
	assign pop      = q_pop && q_valid;
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`RGM_NEVER(a_queue_bound, count_q > CNT_W'(rgm_pkg::QUEUE_DEPTH))

endmodule

### hdl/rgm_div.sv
`include "assert_macros.svh"

module rgm_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [rgm_pkg::GAIN_W-1:0]        dividend,
	input  logic [rgm_pkg::BLOCKS_W-1:0]      divisor,
	output logic                              done,
	output logic [rgm_pkg::GAIN_W-1:0]        quotient
);

	localparam int CNT_W = $clog2(rgm_pkg::GAIN_W + 1);
	localparam int REM_W = rgm_pkg::BLOCKS_W + 1;

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [REM_W-1:0]              rem_q;
	logic [rgm_pkg::GAIN_W-1:0]    quo_q;
	logic [rgm_pkg::BLOCKS_W-1:0]  dsr_q;
	logic [REM_W-1:0]              rem_sh;
	logic                          fits;

	// restoring division, one quotient bit a cycle
	assign rem_sh   = {rem_q[REM_W-2:0], quo_q[rgm_pkg::GAIN_W-1]};
	assign fits     = (rem_sh >= {1'b0, dsr_q});
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			dsr_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(rgm_pkg::GAIN_W);
				rem_q  <= '0;
				quo_q  <= dividend;
				dsr_q  <= divisor;
			end else if (busy_q) begin
				rem_q  <= fits ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
				quo_q  <= {quo_q[rgm_pkg::GAIN_W-2:0], fits};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	`RGM_ASSERT(a_start_busy, start |=> busy_q)

endmodule

### hdl/rgm_back.sv
`include "assert_macros.svh"

module rgm_back #(
	parameter int CHANNELS       = rgm_pkg::DEF_CHANNELS,
	parameter int GAIN_FRAC_BITS = rgm_pkg::DEF_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	input  rgm_pkg::item_t                      q_item,
	output logic                                q_pop,
	input  logic [rgm_pkg::LOG2_W-1:0]          eff_log2,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [rgm_pkg::SAMPLE_W-1:0] mixed_sample,
	output logic                                clipped
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int GW   = rgm_pkg::GAIN_W;
	localparam int AW   = rgm_pkg::ACC_W;

	rgm_pkg::back_state_t state_q, state_d;

	logic signed [GW-1:0]               gain_now_q   [CHANNELS];
	logic signed [GW-1:0]               gbs_q        [CHANNELS];
	logic signed [GW-1:0]               ssamp_q      [CHANNELS];
	logic signed [GW-1:0]               sblk_q       [CHANNELS];
	logic signed [GW-1:0]               target_q     [CHANNELS];
	logic [rgm_pkg::BLOCKS_W-1:0]       left_q       [CHANNELS];
	logic [rgm_pkg::BLOCKS_W-1:0]       pend_q       [CHANNELS];
	logic [rgm_pkg::POS_W-1:0]          bpos_q;
	rgm_pkg::item_t                     item_q;
	logic [CH_W-1:0]                    ch_q;
	logic signed [AW-1:0]               acc_q;
	logic signed [rgm_pkg::PROD_W-1:0]  prod_s1;
	logic                               neg_q;
	logic                               out_valid_q;
	logic signed [rgm_pkg::SAMPLE_W-1:0] mixed_q;
	logic                               clipped_q;

	logic                               div_start;
	logic                               div_done;
	logic [GW-1:0]                      div_quo;
	logic                               fin_go;
	logic signed [GW-1:0]               cur_gn;
	logic signed [GW-1:0]               diff;
	logic [GW-1:0]                      mag;
	logic signed [GW-1:0]               sblk_new;
	logic signed [rgm_pkg::SAMPLE_W-1:0] samp_sel;
	logic signed [AW-1:0]               rounded;
	logic [rgm_pkg::POS_W:0]            bsize;
	logic [rgm_pkg::POS_W:0]            bnext;

	always_comb begin
		samp_sel = '0;
		for (int k = 0; k < rgm_pkg::SAMPLE_INPUTS; k++) begin
			if (32'(ch_q) == k && item_q.present[k]) begin
				samp_sel = $signed(item_q.samples[k]);
			end
		end
	end

	assign cur_gn   = gain_now_q[ch_q];
	assign diff     = target_q[ch_q] - gbs_q[ch_q];
	assign mag      = diff[GW-1] ? GW'(-diff) : GW'(diff);
	assign sblk_new = neg_q ? -$signed(div_quo) : $signed(div_quo);
	assign rounded  = (acc_q + (64'sd1 <<< (GAIN_FRAC_BITS - 1))) >>> GAIN_FRAC_BITS;
	assign bsize    = (rgm_pkg::POS_W + 1)'(1) << eff_log2;
	assign bnext    = {1'b0, bpos_q} + 1'b1;

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		div_start = 1'b0;
		fin_go    = 1'b0;
		case (state_q)
			rgm_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_item.is_ramp == rgm_pkg::OP_FRAME) begin
						state_d = rgm_pkg::ST_CH;
					end
				end
			end
			rgm_pkg::ST_CH: begin
				if (bpos_q == '0 && pend_q[ch_q] != '0) begin
					div_start = 1'b1;
					state_d   = rgm_pkg::ST_DIV;
				end else begin
					state_d = rgm_pkg::ST_BLK;
				end
			end
			rgm_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = rgm_pkg::ST_BLK;
				end
			end
			rgm_pkg::ST_BLK: state_d = rgm_pkg::ST_MLO;
			rgm_pkg::ST_MLO: state_d = rgm_pkg::ST_MHI;
			rgm_pkg::ST_MHI: state_d = rgm_pkg::ST_ACC;
			rgm_pkg::ST_ACC: begin
				if (32'(ch_q) == CHANNELS - 1) begin
					state_d = rgm_pkg::ST_FIN;
				end else begin
					state_d = rgm_pkg::ST_CH;
				end
			end
			rgm_pkg::ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					fin_go  = 1'b1;
					state_d = rgm_pkg::ST_IDLE;
				end
			end
			default: state_d = rgm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rgm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rgm_pkg::ST_MLO: prod_s1 <= samp_sel * $signed({1'b0, cur_gn[rgm_pkg::LO_W-1:0]});
			rgm_pkg::ST_MHI: prod_s1 <= samp_sel * $signed(cur_gn[GW-1:rgm_pkg::LO_W]);
			default: prod_s1 <= prod_s1;
		endcase
		if (q_pop) begin
			item_q <= q_item;
		end
		if (div_start) begin
			neg_q <= diff[GW-1];
		end
		if (fin_go) begin
			if (rounded > rgm_pkg::OUT_MAX) begin
				mixed_q   <= rgm_pkg::OUT_MAX[rgm_pkg::SAMPLE_W-1:0];
				clipped_q <= 1'b1;
			end else if (rounded < rgm_pkg::OUT_MIN) begin
				mixed_q   <= rgm_pkg::OUT_MIN[rgm_pkg::SAMPLE_W-1:0];
				clipped_q <= 1'b1;
			end else begin
				mixed_q   <= rounded[rgm_pkg::SAMPLE_W-1:0];
				clipped_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				gain_now_q[c] <= '0;
				gbs_q[c]      <= '0;
				ssamp_q[c]    <= '0;
				sblk_q[c]     <= '0;
				target_q[c]   <= '0;
				left_q[c]     <= '0;
				pend_q[c]     <= '0;
			end
			bpos_q      <= '0;
			ch_q        <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				ch_q  <= '0;
				acc_q <= '0;
			end
			for (int c = 0; c < CHANNELS; c++) begin
				if (q_pop && q_item.is_ramp == rgm_pkg::OP_RAMP && 32'(q_item.channel) == c) begin
					target_q[c] <= GW'($signed(q_item.target));
					if (q_item.blocks == '0) begin
						gbs_q[c]      <= GW'($signed(q_item.target));
						gain_now_q[c] <= GW'($signed(q_item.target));
						ssamp_q[c]    <= '0;
						left_q[c]     <= '0;
						pend_q[c]     <= '0;
					end else begin
						pend_q[c] <= q_item.blocks;
					end
				end
			end
			if (state_q == rgm_pkg::ST_DIV && div_done) begin
				sblk_q[ch_q]  <= sblk_new;
				ssamp_q[ch_q] <= sblk_new >>> eff_log2;
				left_q[ch_q]  <= pend_q[ch_q];
				pend_q[ch_q]  <= '0;
			end
			if (state_q == rgm_pkg::ST_BLK && bpos_q == '0) begin
				if (left_q[ch_q] != '0) begin
					gain_now_q[ch_q] <= gbs_q[ch_q];
					gbs_q[ch_q]      <= gbs_q[ch_q] + sblk_q[ch_q];
					left_q[ch_q]     <= left_q[ch_q] - 1'b1;
				end else begin
					gbs_q[ch_q]      <= target_q[ch_q];
					gain_now_q[ch_q] <= target_q[ch_q];
					ssamp_q[ch_q]    <= '0;
				end
			end
			if (state_q == rgm_pkg::ST_MHI) begin
				acc_q <= acc_q + AW'(prod_s1);
			end
			if (state_q == rgm_pkg::ST_ACC) begin
				acc_q            <= acc_q + (AW'(prod_s1) <<< rgm_pkg::LO_W);
				gain_now_q[ch_q] <= cur_gn + ssamp_q[ch_q];
				ch_q             <= ch_q + 1'b1;
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
				bpos_q      <= (bnext >= bsize) ? '0 : bnext[rgm_pkg::POS_W-1:0];
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	rgm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  (pend_q[ch_q]),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign out_valid    = out_valid_q;
	assign mixed_sample = mixed_q;
	assign clipped      = clipped_q;

	`RGM_ASSERT(a_fin_all_ch, (state_q == rgm_pkg::ST_FIN) |-> (32'(ch_q) == CHANNELS % (1 << CH_W)))
	`RGM_ASSERT(a_div_only_wait, div_done |-> (state_q == rgm_pkg::ST_DIV))

endmodule

### hdl/ramped_gain_mixer.sv
// channel | direction | handshake          | contents
// in      | input     | in_valid/in_stall   | frame samples or a set-ramp command
// out     | output    | out_valid/out_stall | mixed sample and clip flag
// cfg     | input     | cfg_valid/cfg_ready | block_size_log2, always ready
//
// a frame item leaves idle, runs ch, blk, mlo, mhi and acc for each channel, then fin
// a channel whose ramp arms at a block start also waits in div for the shared bit-serial divider
// set-ramp items retire in the back end's idle state, without a pass over the channels
// the four-entry item queue lets the input keep flowing while the back end computes, until it fills
// the output register holds a result under out_stall; the back end waits only to write a new one
// reset is asynchronous: gains, ramps, block position and queue all clear, block size returns to 64 samples

`include "assert_macros.svh"

module ramped_gain_mixer #(
	parameter int CHANNELS       = rgm_pkg::DEF_CHANNELS,
	parameter int GAIN_FRAC_BITS = rgm_pkg::DEF_FRAC_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rgm_pkg::LOG2_W-1:0]           block_size_log2,
	// input items
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 operation,
	input  logic [1:0]                           channel,
	input  logic signed [rgm_pkg::SAMPLE_W-1:0]  target_gain,
	input  logic [rgm_pkg::BLOCKS_W-1:0]         ramp_blocks,
	input  logic signed [rgm_pkg::SAMPLE_W-1:0]  sample_0,
	input  logic signed [rgm_pkg::SAMPLE_W-1:0]  sample_1,
	input  logic signed [rgm_pkg::SAMPLE_W-1:0]  sample_2,
	input  logic signed [rgm_pkg::SAMPLE_W-1:0]  sample_3,
	input  logic [rgm_pkg::SAMPLE_INPUTS-1:0]    channel_present,
	// result items
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [rgm_pkg::SAMPLE_W-1:0]  mixed_sample,
	output logic                                 clipped
);

	logic [rgm_pkg::LOG2_W-1:0] log2_q;
	logic [rgm_pkg::LOG2_W-1:0] eff_log2;
	rgm_pkg::item_t             in_item;
	rgm_pkg::item_t             q_item;
	logic                       q_valid;
	logic                       q_pop;

	// config register, write any time the block is idle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_q <= rgm_pkg::LOG2_RESET;
		end else if (cfg_valid && cfg_ready) begin
			log2_q <= block_size_log2;
		end
	end

	// block sizes above 1024 samples clamp to 1024
	assign eff_log2 = (log2_q > rgm_pkg::MAX_LOG2) ? rgm_pkg::MAX_LOG2 : log2_q;

	// pack the input fields into one queue item
	always_comb begin
		in_item.is_ramp    = operation;
		in_item.channel    = channel;
		in_item.target     = target_gain;
		in_item.blocks     = ramp_blocks;
		in_item.samples[0] = sample_0;
		in_item.samples[1] = sample_1;
		in_item.samples[2] = sample_2;
		in_item.samples[3] = sample_3;
		in_item.present    = channel_present;
	end

	// front end: accepts, drops ramp commands for missing channels, queues
	rgm_front #(
		.CHANNELS (CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// back end: ramp bookkeeping, per-channel multiply-accumulate, rounding, clipping, output register
	rgm_back #(
		.CHANNELS       (CHANNELS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.eff_log2     (eff_log2),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mixed_sample (mixed_sample),
		.clipped      (clipped)
	);

	// a write must land in the register in the cycle after it is accepted
	`RGM_ASSERT(a_cfg_write, (cfg_valid && cfg_ready) |=> (log2_q == $past(block_size_log2)))

endmodule

### verif/tb_ramped_gain_mixer.sv
`timescale 1ns / 100ps

module tb_ramped_gain_mixer;

	localparam int NCH = 4;
	localparam int FRAC = 20;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 950;
	localparam int DRAIN_CYCLES = 300;
	localparam int S24_HI = 8388607;
	localparam int S24_LO = -8388608;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [rgm_pkg::LOG2_W-1:0] block_size_log2 = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic operation = rgm_pkg::OP_FRAME;
	logic [1:0] channel = '0;
	logic signed [rgm_pkg::SAMPLE_W-1:0] target_gain = '0;
	logic [rgm_pkg::BLOCKS_W-1:0] ramp_blocks = '0;
	logic signed [rgm_pkg::SAMPLE_W-1:0] sample_0 = '0, sample_1 = '0, sample_2 = '0, sample_3 = '0;
	logic [rgm_pkg::SAMPLE_INPUTS-1:0] channel_present = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [rgm_pkg::SAMPLE_W-1:0] mixed_sample;
	logic clipped;

	typedef struct {
		logic signed [rgm_pkg::SAMPLE_W-1:0] mix;
		logic clip;
	} mix_result_t;

	rgm_pkg::item_t pending_items[$];
	mix_result_t expected_mix[$];
	int errors = 0;
	int frames_sent = 0;
	int ramps_sent = 0;
	int idle_cycles = 0;
	int gap_left = 0;
	int stall_left = 0;
	bit stim_done = 1'b0;
	bit hold_input = 1'b0;
	bit in_held = 1'b0;

	// mirrored block state
	logic [3:0] mdl_log2;
	longint gain_now[NCH], gain_blk[NCH], step_smp[NCH], step_blk[NCH], gain_tgt[NCH];
	int unsigned blocks_left[NCH], ramp_pend[NCH];
	int unsigned blk_pos;

	always #10 clk = ~clk;

	ramped_gain_mixer i_dut (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .block_size_log2,
		.in_valid, .in_stall, .operation, .channel, .target_gain, .ramp_blocks,
		.sample_0, .sample_1, .sample_2, .sample_3, .channel_present,
		.out_valid, .out_stall, .mixed_sample, .clipped
	);

	function automatic int rand_gap();
		// mostly short gaps, sometimes long ones
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
		return $urandom_range(0, 3);
	endfunction

	function automatic longint floor_sh(longint x, int s);
		return x >>> s;
	endfunction

	function automatic int unsigned eff_log2();
		return (mdl_log2 > 4'd10) ? 10 : int'(mdl_log2);
	endfunction

	// arm a pending ramp and step one block border for channel c
	task automatic enter_block(int c);
		longint diff, mag;
		if (ramp_pend[c] != 0) begin
			diff = gain_tgt[c] - gain_blk[c];
			mag = (diff < 0 ? -diff : diff) / longint'(ramp_pend[c]);
			step_blk[c] = diff < 0 ? -mag : mag;
			step_smp[c] = floor_sh(step_blk[c], eff_log2());
			blocks_left[c] = ramp_pend[c];
			ramp_pend[c] = 0;
		end
		if (blocks_left[c] != 0) begin
			gain_now[c] = gain_blk[c];
			gain_blk[c] += step_blk[c];
			blocks_left[c]--;
		end else begin
			gain_blk[c] = gain_tgt[c];
			gain_now[c] = gain_tgt[c];
			step_smp[c] = 0;
		end
	endtask

	task automatic predict_mix(rgm_pkg::item_t it);
		longint sum, y;
		logic [rgm_pkg::SAMPLE_W-1:0] smp;
		mix_result_t r;
		int unsigned size;
		int c;
		if (it.is_ramp == rgm_pkg::OP_RAMP) begin
			c = int'(it.channel);
			gain_tgt[c] = longint'($signed(it.target));
			if (it.blocks == 0) begin
				gain_blk[c] = gain_tgt[c];
				gain_now[c] = gain_tgt[c];
				step_smp[c] = 0;
				blocks_left[c] = 0;
				ramp_pend[c] = 0;
			end else begin
				ramp_pend[c] = 32'(it.blocks);
			end
			return;
		end
		sum = 0;
		size = 1 << eff_log2();
		for (c = 0; c < NCH; c++) begin
			if (blk_pos == 0) enter_block(c);
			smp = it.samples[c];
			if (it.present[c]) sum += longint'($signed(smp)) * gain_now[c];
			gain_now[c] += step_smp[c];
		end
		y = floor_sh(sum + (64'sd1 <<< (FRAC - 1)), FRAC);
		r.clip = 1'b0;
		if (y > S24_HI) begin
			y = S24_HI;
			r.clip = 1'b1;
		end
		if (y < S24_LO) begin
			y = S24_LO;
			r.clip = 1'b1;
		end
		r.mix = y[rgm_pkg::SAMPLE_W-1:0];
		expected_mix.push_back(r);
		blk_pos = (blk_pos + 1 >= size) ? 0 : blk_pos + 1;
	endtask

	function automatic logic [rgm_pkg::SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'($urandom_range(0, 255));
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [rgm_pkg::SAMPLE_W-1:0] rand_gain();
		case ($urandom_range(0, 5))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'h100000;
			3: return 24'hF00000;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic rgm_pkg::item_t make_frame(logic [3:0] present);
		rgm_pkg::item_t it;
		it = '0;
		it.is_ramp = rgm_pkg::OP_FRAME;
		for (int c = 0; c < rgm_pkg::SAMPLE_INPUTS; c++) it.samples[c] = rand_sample();
		it.present = present;
		// unused fields carry noise
		it.channel = 2'($urandom);
		it.target = 24'($urandom);
		it.blocks = 16'($urandom);
		return it;
	endfunction

	function automatic rgm_pkg::item_t make_ramp(int c, logic [rgm_pkg::SAMPLE_W-1:0] tgt,
		int blocks);
		rgm_pkg::item_t it;
		it = make_frame(4'($urandom));
		it.is_ramp = rgm_pkg::OP_RAMP;
		it.channel = 2'(c);
		it.target = tgt;
		it.blocks = 16'(blocks);
		return it;
	endfunction

	// driver: inputs change on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && in_held) begin
				// hold the payload
			end else if (gap_left > 0 || hold_input || pending_items.size() == 0) begin
				if (gap_left > 0) gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else begin
				rgm_pkg::item_t it;
				it = pending_items.pop_front();
				in_valid <= 1'b1;
				operation <= it.is_ramp;
				channel <= it.channel;
				target_gain <= it.target;
				ramp_blocks <= it.blocks;
				sample_0 <= it.samples[0];
				sample_1 <= it.samples[1];
				sample_2 <= it.samples[2];
				sample_3 <= it.samples[3];
				channel_present <= it.present;
				gap_left <= rand_gap();
			end
			// output side stall
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 2) == 0) stall_left <= rand_gap();
			end
		end
	end

	// monitor: everything sampled at the rising edge
	always @(posedge clk) begin
		bit seen;
		seen = 1'b0;
		if (arst_n) begin
			in_held <= in_valid && in_stall;
			if (in_valid && !in_stall) begin
				rgm_pkg::item_t it;
				it.is_ramp = operation;
				it.channel = channel;
				it.target = target_gain;
				it.blocks = ramp_blocks;
				it.samples[0] = sample_0;
				it.samples[1] = sample_1;
				it.samples[2] = sample_2;
				it.samples[3] = sample_3;
				it.present = channel_present;
				predict_mix(it);
				if (operation == rgm_pkg::OP_RAMP) ramps_sent <= ramps_sent + 1;
				else frames_sent <= frames_sent + 1;
				seen = 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				mdl_log2 = block_size_log2;
				seen = 1'b1;
			end
			if (out_valid && !out_stall) begin
				seen = 1'b1;
				if (expected_mix.size() == 0) begin
					$display("%0t: unexpected result mix=%0d clip=%0b", $time,
						mixed_sample, clipped);
					errors <= errors + 1;
				end else begin
					mix_result_t e;
					e = expected_mix.pop_front();
					if (mixed_sample !== e.mix || clipped !== e.clip) begin
						$display("%0t: mismatch expected mix=%0d clip=%0b actual mix=%0d clip=%0b",
							$time, e.mix, e.clip, mixed_sample, clipped);
						errors <= errors + 1;
					end
				end
			end
			idle_cycles <= seen ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_ramped_gain_mixer: errors");
				$finish;
			end
		end
	end

	// wait until every queued item is in and every result is out
	task automatic drain();
		while (pending_items.size() != 0 || in_valid) @(posedge clk);
		while (expected_mix.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_block_size(logic [3:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		block_size_log2 <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one phase of random traffic, mostly frames with ramps mixed in
	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				int blocks;
				case ($urandom_range(0, 4))
					0: blocks = 0;
					1: blocks = 65535;
					2: blocks = $urandom;
					default: blocks = $urandom_range(1, 4);
				endcase
				pending_items.push_back(make_ramp(int'($urandom_range(0, 3)), rand_gain(),
					blocks));
			end else begin
				pending_items.push_back(make_frame(4'($urandom)));
			end
		end
	endtask

	initial begin
		mdl_log2 = rgm_pkg::LOG2_RESET;
		for (int c = 0; c < NCH; c++) begin
			gain_now[c] = 0; gain_blk[c] = 0; step_smp[c] = 0; step_blk[c] = 0;
			gain_tgt[c] = 0; blocks_left[c] = 0; ramp_pend[c] = 0;
		end
		blk_pos = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: zero gains at reset, then jumps to extremes, with full, empty and partial present masks
		pending_items.push_back(make_frame(4'hF));
		for (int c = 0; c < NCH; c++)
			pending_items.push_back(make_ramp(c, 24'h7FFFFF, 0));
		pending_items.push_back(make_frame(4'hF));
		pending_items.push_back(make_frame(4'h0));
		for (int c = 0; c < NCH; c++)
			pending_items.push_back(make_ramp(c, 24'h800000, 0));
		pending_items.push_back(make_frame(4'hF));
		pending_items.push_back(make_frame(4'h5));
		// ramps armed at the next block border, then a re-set of a pending ramp before that border
		pending_items.push_back(make_ramp(0, 24'h100000, 2));
		pending_items.push_back(make_ramp(1, 24'h7FFFFF, 65535));
		pending_items.push_back(make_frame(4'hA));
		pending_items.push_back(make_ramp(0, 24'hF00000, 3));
		for (int i = 0; i < 4; i++) pending_items.push_back(make_frame(4'($urandom)));
		drain();

		// small blocks so ramps get through many borders
		write_block_size(4'd0);
		random_phase(150);
		drain();
		write_block_size(4'd1);
		random_phase(200);
		// sender holds off until every result is back
		while (pending_items.size() != 0 || in_valid) @(posedge clk);
		hold_input = 1'b1;
		while (expected_mix.size() != 0) @(posedge clk);
		hold_input = 1'b0;
		drain();
		write_block_size(4'd2);
		random_phase(200);
		// size change mid-block: no drain before the next phase on purpose is not
		// allowed, so the change lands at a random block position instead
		drain();
		write_block_size(4'd3);
		random_phase(150);
		drain();
		write_block_size(4'd10);
		random_phase(100);
		drain();
		write_block_size(4'd15);
		random_phase(100);
		drain();
		write_block_size(4'd6);
		random_phase(50);
		drain();

		$display("covered %0d frames and %0d ramp commands over block sizes 1 to 1024",
			frames_sent, ramps_sent);
		if (errors == 0) begin
			$display("tb_ramped_gain_mixer: clean");
		end else begin
			$display("tb_ramped_gain_mixer: errors");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/rgm_pkg.sv
hdl/rgm_front.sv
hdl/rgm_div.sv
hdl/rgm_back.sv
hdl/ramped_gain_mixer.sv
verif/tb_ramped_gain_mixer.sv
